[design/mhjs_pkg.sv]
// Shared types, constants and the heap ordering function for the job scheduler.
`timescale 1ns / 1ps

package mhjs_pkg;

  localparam int TIME_W          = 48;
  localparam int ID_W            = 6;
  localparam int DUR_W           = 32;
  localparam int CNT_W           = 7;
  localparam int MAX_WORKERS_DEF = 64;
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  // One heap slot: finish time and the worker that owns it
  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [ID_W-1:0]   wid;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_load;  // take a new worker count
    logic clr_rst;   // restart the clearing pass
    logic clr_step;  // write one cleared slot
    logic in_take;   // capture duration, read the root
    logic root_go;   // emit result, start the sift-down
    logic cap_left;  // capture left child, read right child
    logic decide;    // compare, write one slot, read the next left child
    logic last_wr;   // park the sinking entry at its slot
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;   // clearing pass at its last slot
    logic out_free;   // output register can take a result
    logic has_left0;  // root has a child
    logic swap;       // best child orders before the sinking entry
    logic next_left;  // the slot moved into has a child
  } stat_t;

  // True when a orders before b: earlier time, then lower worker id
  function automatic logic earlier(entry_t a, entry_t b);
    earlier = (a.ftime < b.ftime) || ((a.ftime == b.ftime) && (a.wid < b.wid));
  endfunction

endpackage

[design/min_heap_job_scheduler.sv]
// A job is taken in IDLE as the root slot is read; in ROOT_WAIT the result goes to
// the output register once it is free (a result waiting on m_tready stalls this) and
// m_tvalid rises. A new job is taken only after the sift-down of the last one ends:
// on the single read port of the heap RAM each level captures the left child and
// reads the right one (LEVEL_R), then compares and writes one slot (DECIDE); LAST_WR
// parks the entry in a slot with no children. Reset and every worker_count write run
// a clearing pass (times 0, slot i holding worker i) during which no job is taken.
`timescale 1ns / 1ps

module min_heap_job_scheduler #(
  parameter int MAX_WORKERS = mhjs_pkg::MAX_WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] job_duration
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [5:0] worker_index, [53:6] start_time, [55:54] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // worker_count
);

  mhjs_pkg::cmd_t  cmd;
  mhjs_pkg::stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  mhjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  mhjs_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

[design/mhjs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mhjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/mhjs_dp.sv]
// Datapath: heap memory, sinking entry, child compare, clear counter, output register.
`timescale 1ns / 1ps

module mhjs_dp #(
  parameter int MAX_WORKERS = mhjs_pkg::MAX_WORKERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mhjs_pkg::cmd_t              cmd,
  output mhjs_pkg::stat_t             stat,
  input  logic [mhjs_pkg::DUR_W-1:0]  in_data,
  input  logic [mhjs_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [55:0]                 out_data
);

  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW = AW + 1;
  localparam int PW = AW + 2;
  localparam int XW = (NW > mhjs_pkg::CNT_W) ? NW : mhjs_pkg::CNT_W;
  localparam int TW = mhjs_pkg::TIME_W;
  localparam int IW = mhjs_pkg::ID_W;
  localparam int EW = $bits(mhjs_pkg::entry_t);

  // Registers
  logic [mhjs_pkg::CNT_W-1:0] wcount;
  logic [mhjs_pkg::DUR_W-1:0] dur;
  mhjs_pkg::entry_t           cur;
  mhjs_pkg::entry_t           left;
  logic                       right_ok;
  logic [AW-1:0]              pos;
  logic [AW-1:0]              clr_addr;
  logic [IW-1:0]              out_idx;
  logic [TW-1:0]              out_time;

  // Memory ports
  logic             we;
  logic [AW-1:0]    waddr;
  mhjs_pkg::entry_t wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  mhjs_pkg::entry_t rdata;

  // Combinational terms
  logic [XW-1:0]    wc_ext;
  logic [XW-1:0]    n_full;
  logic [NW-1:0]    n;
  logic [PW-1:0]    lft_pos;
  logic [PW-1:0]    rgt_pos;
  logic [PW-1:0]    nl_pos;
  logic             has_right;
  logic             best_is_right;
  mhjs_pkg::entry_t best;
  logic [AW-1:0]    best_idx;
  logic             swap;
  logic [TW:0]      sum;
  mhjs_pkg::entry_t root_new;

  // Active heap size: zero acts as one, clamp at the heap depth
  always_comb begin
    wc_ext = XW'(wcount);
    if (wcount == '0) begin
      n_full = XW'(1);
    end else if (wc_ext > XW'(MAX_WORKERS)) begin
      n_full = XW'(MAX_WORKERS);
    end else begin
      n_full = wc_ext;
    end
    n = n_full[NW-1:0];
  end

  // Child positions and best-child selection
  assign lft_pos       = PW'({pos, 1'b1});
  assign rgt_pos       = lft_pos + PW'(1);
  assign has_right     = rgt_pos < PW'(n);
  assign best_is_right = right_ok && mhjs_pkg::earlier(rdata, left);
  assign best          = best_is_right ? rdata : left;
  assign best_idx      = best_is_right ? rgt_pos[AW-1:0] : lft_pos[AW-1:0];
  assign swap          = mhjs_pkg::earlier(best, cur);
  assign nl_pos        = PW'({best_idx, 1'b1});

  // Root finish time plus duration, saturating
  assign sum            = {1'b0, rdata.ftime} + (TW + 1)'(dur);
  assign root_new.ftime = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign root_new.wid   = rdata.wid;

  // Status
  assign stat.clr_last  = (clr_addr == AW'(MAX_WORKERS - 1));
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.has_left0 = n > NW'(1);
  assign stat.swap      = swap;
  assign stat.next_left = nl_pos < PW'(n);

  // Read port select
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd.in_take) begin
      re = 1'b1;
    end else if (cmd.root_go) begin
      re    = stat.has_left0;
      raddr = AW'(1);
    end else if (cmd.cap_left) begin
      re    = has_right;
      raddr = rgt_pos[AW-1:0];
    end else if (cmd.decide) begin
      re    = swap && stat.next_left;
      raddr = nl_pos[AW-1:0];
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    if (cmd.clr_step) begin
      we          = 1'b1;
      waddr       = clr_addr;
      wdata.ftime = '0;
      wdata.wid   = IW'(clr_addr);
    end else if (cmd.decide) begin
      we    = 1'b1;
      wdata = swap ? best : cur;
    end else if (cmd.last_wr) begin
      we = 1'b1;
    end
  end

  mhjs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WORKERS)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wcount    <= mhjs_pkg::COUNT_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cfg_load) begin
        wcount <= cfg_data;
      end
      if (cmd.clr_rst) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.root_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      dur <= in_data;
    end
    if (cmd.root_go) begin
      out_idx  <= rdata.wid;
      out_time <= rdata.ftime;
      cur      <= root_new;
      pos      <= '0;
    end
    if (cmd.cap_left) begin
      left     <= rdata;
      right_ok <= has_right;
    end
    if (cmd.decide && swap) begin
      pos <= best_idx;
    end
  end

  assign out_data = {2'b00, out_time, out_idx};

  // The sift-down only ever works on a slot inside the active heap
  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (NW'(pos) < n))
    else $error("sift-down slot outside active heap");

  // Every swap moves the sinking entry strictly deeper
  a_descend: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && swap) |=> (pos > $past(pos)))
    else $error("sift-down did not move down");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.root_go |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

endmodule

[design/mhjs_ctrl.sv]
// Controller state machine: clearing pass, job intake, sift-down sequencing.
`timescale 1ns / 1ps

module mhjs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  input  mhjs_pkg::stat_t stat,
  output mhjs_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    ROOT_WAIT,
    LEVEL_R,
    DECIDE,
    LAST_WR
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE) && !cfg_valid;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    if (cfg_valid) begin
      // a register write restarts the clearing pass
      cmd.cfg_load = 1'b1;
      cmd.clr_rst  = 1'b1;
      state_next   = CLEAR;
    end else begin
      case (state)
        CLEAR: begin
          cmd.clr_step = 1'b1;
          if (stat.clr_last) begin
            state_next = IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            cmd.in_take = 1'b1;
            state_next  = ROOT_WAIT;
          end
        end
        ROOT_WAIT: begin
          if (stat.out_free) begin
            cmd.root_go = 1'b1;
            state_next  = stat.has_left0 ? LEVEL_R : LAST_WR;
          end
        end
        LEVEL_R: begin
          cmd.cap_left = 1'b1;
          state_next   = DECIDE;
        end
        DECIDE: begin
          cmd.decide = 1'b1;
          if (!stat.swap) begin
            state_next = IDLE;
          end else if (stat.next_left) begin
            state_next = LEVEL_R;
          end else begin
            state_next = LAST_WR;
          end
        end
        LAST_WR: begin
          cmd.last_wr = 1'b1;
          state_next  = IDLE;
        end
        default: begin
          state_next = CLEAR;
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the min-heap job scheduler with a heap predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int TIME_W = mhjs_pkg::TIME_W;
  localparam int ID_W   = mhjs_pkg::ID_W;
  localparam int DUR_W  = mhjs_pkg::DUR_W;
  localparam int CNT_W  = mhjs_pkg::CNT_W;
  localparam logic [CNT_W-1:0] COUNT_RESET = mhjs_pkg::COUNT_RESET;
  localparam int MAX_W = mhjs_pkg::MAX_WORKERS_DEF;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam int IDLE_PCT = 36;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_JOBS = 100;
  localparam int STEADY_PHASE = 3;

  typedef enum logic {STEP_JOB, STEP_CFG} step_kind_t;

  // One row of the directed sequence: a job (value = duration) or a
  // worker_count write (value = count); known rows carry their expected result
  typedef struct packed {
    step_kind_t        kind;
    logic [DUR_W-1:0]  value;
    logic              known;
    logic [ID_W-1:0]   worker;
    logic [TIME_W-1:0] start;
  } step_t;

  typedef struct packed {
    logic [ID_W-1:0]   worker;
    logic [TIME_W-1:0] start;
  } assignment_t;

  localparam int DIRECTED_LEN = 25;
  localparam step_t DIRECTED_STEPS [0:DIRECTED_LEN-1] = '{
    // reset contents, 64 workers
    '{STEP_JOB, 32'h0000_0000, 1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'hFFFF_FFFF, 1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'd10,        1'b1, 6'd1, 48'd0},
    '{STEP_JOB, 32'd1,         1'b1, 6'd2, 48'd0},
    // zero count acts as one worker
    '{STEP_CFG, 32'd0,         1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'd5,         1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'hFFFF_FFFF, 1'b1, 6'd0, 48'd5},
    '{STEP_JOB, 32'd0,         1'b1, 6'd0, 48'h1_0000_0004},
    // all-ones count clamps to 64; zero-length jobs keep worker 1 at the root
    '{STEP_CFG, 32'd127,       1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'd7,         1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'd0,         1'b1, 6'd1, 48'd0},
    '{STEP_JOB, 32'd0,         1'b1, 6'd1, 48'd0},
    // two workers: equal finish times go to the lower index
    '{STEP_CFG, 32'd2,         1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'd3,         1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'd3,         1'b1, 6'd1, 48'd0},
    '{STEP_JOB, 32'd1,         1'b1, 6'd0, 48'd3},
    '{STEP_JOB, 32'd0,         1'b1, 6'd1, 48'd3},
    // one above the maximum
    '{STEP_CFG, 32'd65,        1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'hAAAA_AAAA, 1'b1, 6'd0, 48'd0},
    '{STEP_JOB, 32'h5555_5555, 1'b1, 6'd1, 48'd0},
    '{STEP_CFG, 32'd64,        1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'h8000_0000, 1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'd1,         1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'd2,         1'b0, 6'd0, 48'd0},
    '{STEP_JOB, 32'hFFFF_FFFF, 1'b0, 6'd0, 48'd0}
  };

  localparam logic [CNT_W-1:0] PHASE_COUNTS [0:7] = '{
    7'd3, 7'd127, 7'd0, 7'd64, 7'd2, 7'd65, 7'd5, 7'd31
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [DUR_W-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [55:0]      m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Predicted heap and worker count
  logic [TIME_W-1:0] sched_time [MAX_W];
  logic [ID_W-1:0]   sched_id [MAX_W];
  logic [CNT_W-1:0]  sched_count;

  assignment_t pending_assignments [$];
  int          error_count = 0;
  int          stall_cycles = 0;
  bit          steady_flow = 1'b0;

  min_heap_job_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] job_duration
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [5:0] worker_index, [53:6] start_time
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // worker_count
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Heap back to all times zero, slot i owned by worker i
  function automatic void clear_schedule();
    for (int k = 0; k < MAX_W; k++) begin
      sched_time[k] = '0;
      sched_id[k] = ID_W'(k);
    end
  endfunction

  function automatic bit runs_first(int a, int b);
    if (sched_time[a] != sched_time[b]) return sched_time[a] < sched_time[b];
    return sched_id[a] < sched_id[b];
  endfunction

  // Hand the job to the root worker, extend its finish time, sink the root
  function automatic assignment_t schedule_job(logic [DUR_W-1:0] dur);
    assignment_t       got;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] t_swap;
    logic [ID_W-1:0]   w_swap;
    int                n;
    int                pos;
    int                best;
    got.worker = sched_id[0];
    got.start = sched_time[0];
    sum = {1'b0, sched_time[0]} + dur;
    sched_time[0] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    n = (sched_count == 0) ? 1 : (sched_count > MAX_W) ? MAX_W : int'(sched_count);
    pos = 0;
    while (2 * pos + 1 < n) begin
      best = pos;
      if (runs_first(2 * pos + 1, best)) best = 2 * pos + 1;
      if (2 * pos + 2 < n && runs_first(2 * pos + 2, best)) best = 2 * pos + 2;
      if (best == pos) break;
      t_swap = sched_time[pos];
      sched_time[pos] = sched_time[best];
      sched_time[best] = t_swap;
      w_swap = sched_id[pos];
      sched_id[pos] = sched_id[best];
      sched_id[best] = w_swap;
      pos = best;
    end
    return got;
  endfunction

  // Mostly short and tied durations, with zeros, extremes and full-range values
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return DUR_W'($urandom_range(1, 7));
      4:       return '1;
      5, 6:    return DUR_W'($urandom_range(0, 1000));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // One job transfer with random gaps ahead of it outside the steady stretch; the
  // expectation is queued on acceptance
  task automatic send_job(input logic [DUR_W-1:0] dur, input logic known,
                          input logic [ID_W-1:0] worker, input logic [TIME_W-1:0] start);
    assignment_t predicted;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= dur;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = schedule_job(dur);
    if (known) begin
      predicted.worker = worker;
      predicted.start = start;
    end
    pending_assignments = {pending_assignments, predicted};
  endtask

  // Register write once every queued result has come back
  task automatic write_worker_count(input logic [CNT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sched_count = value;
    clear_schedule();
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < 10) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Result side: random stalls except during the steady stretch
  always @(posedge clk) begin
    m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    assignment_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_assignments.size() == 0) begin
        report_mismatch($sformatf("unexpected result worker %0d start %0h",
                                  m_tdata[5:0], m_tdata[53:6]));
      end else begin
        want = pending_assignments.pop_front();
        if (m_tdata[5:0] !== want.worker || m_tdata[53:6] !== want.start)
          report_mismatch($sformatf("got worker %0d start %0h, expected worker %0d start %0h",
                                    m_tdata[5:0], m_tdata[53:6], want.worker, want.start));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("min_heap_job_scheduler test failed");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] count;
    sched_count = COUNT_RESET;
    clear_schedule();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_STEPS[i].kind == STEP_CFG)
        write_worker_count(DIRECTED_STEPS[i].value[CNT_W-1:0]);
      else
        send_job(DIRECTED_STEPS[i].value, DIRECTED_STEPS[i].known,
                 DIRECTED_STEPS[i].worker, DIRECTED_STEPS[i].start);
    end

    // Random phases, each under a fresh worker count; one runs with no idling
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase < 8)
        count = PHASE_COUNTS[phase];
      else if ($urandom_range(0, 1) == 1)
        count = CNT_W'($urandom_range(1, 16));
      else
        count = CNT_W'($urandom_range(0, 127));
      write_worker_count(count);
      steady_flow = (phase == STEADY_PHASE);
      repeat (PHASE_JOBS) send_job(pick_duration(), 1'b0, '0, '0);
      steady_flow = 1'b0;
    end

    // Drain, then keep watching for stray results before the verdict
    s_tvalid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_assignments.size() == 0) begin
      $display("min_heap_job_scheduler test passed");
    end else begin
      $display("min_heap_job_scheduler test failed");
    end
    $finish;
  end

endmodule

[min_heap_job_scheduler.f]
design/mhjs_pkg.sv
design/mhjs_ram.sv
design/mhjs_dp.sv
design/mhjs_ctrl.sv
design/min_heap_job_scheduler.sv
tb/tb_top.sv
